// ===== src/tdt_pkg.sv =====
`timescale 1ns / 1ps

package tdt_pkg;

    // Field widths of the request and result beats
    localparam int STATE_W  = 6;
    localparam int CHAR_W   = 8;
    localparam int TOKEN_W  = 4;
    localparam int LENGTH_W = 8;

    // Every state code the state fields can carry
    localparam int STATE_SPACE = 2 ** STATE_W;

    // Defaults for the top-level parameters
    localparam int NUM_STATES_DEF = 64;
    localparam int MAX_LEXEME_DEF = 255;

    // Token codes an accept write may install
    localparam int NUM_TOKEN_KINDS = 13;

    // Result queue: depth and the most results one request can raise
    localparam int RES_FIFO_DEPTH   = 8;
    localparam int RES_MAX_PER_ITEM = 2;

    // Blank characters: walk the automaton but do not add to a token's length
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        REQ_CHAR      = 2'd0,
        REQ_END       = 2'd1,
        REQ_WR_TRANS  = 2'd2,
        REQ_WR_ACCEPT = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        RES_TOKEN   = 2'd0,
        RES_INVALID = 2'd1,
        RES_END     = 2'd2
    } t_res_kind;

    // One entry of the transition memory
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] next_state;
    } t_trans;

    // One queued result beat
    typedef struct packed {
        t_res_kind           kind;
        logic [TOKEN_W-1:0]  token_kind;
        logic [LENGTH_W-1:0] lexeme_length;
        logic                last;
    } t_result;

endpackage

// ===== src/tdt_req_if.sv =====
`timescale 1ns / 1ps

interface tdt_req_if;
    logic                           valid;
    logic                           ready;
    tdt_pkg::t_req_type             req_type;
    logic [tdt_pkg::CHAR_W-1:0]     char_code;
    logic [tdt_pkg::STATE_W-1:0]    from_state;
    logic [tdt_pkg::STATE_W-1:0]    to_state;
    logic                           entry_valid;
    logic [tdt_pkg::TOKEN_W-1:0]    token_kind_in;

    modport source (
        output valid, req_type, char_code, from_state, to_state, entry_valid, token_kind_in,
        input  ready
    );

    modport sink (
        input  valid, req_type, char_code, from_state, to_state, entry_valid, token_kind_in,
        output ready
    );
endinterface

// ===== src/tdt_res_if.sv =====
`timescale 1ns / 1ps

interface tdt_res_if;
    logic                           valid;
    logic                           ready;
    tdt_pkg::t_res_kind             result_kind;
    logic [tdt_pkg::TOKEN_W-1:0]    token_kind;
    logic [tdt_pkg::LENGTH_W-1:0]   lexeme_length;
    logic                           last;

    modport source (
        output valid, result_kind, token_kind, lexeme_length, last,
        input  ready
    );

    modport sink (
        input  valid, result_kind, token_kind, lexeme_length, last,
        output ready
    );
endinterface

// ===== src/table_dfa_tokenizer.sv =====
`timescale 1ns / 1ps

// Table-driven DFA tokenizer with maximal munch.
// i_req carries request beats: characters, end of input, transition writes
// and accept-entry writes. o_res carries result beats: token found, invalid
// text skipped, end of input; last marks the final result of one request.
// i_cfg_we / i_cfg_wdata set the start state; write it only while idle.
// A character or end request is looked up in the cycle it is taken (transition
// memory read at the current and the start state, accept memory read) and is
// resolved in the next; its results enter the result queue at the following
// clock edge. The next state drives the following read address straight from the
// registered memory data, so one request can be taken every cycle while
// i_req.ready is high. Table writes raise no result.
// After reset the transition memory is cleared one entry a cycle, all ROWS x 256
// entries (ROWS is NUM_STATES, at most 64; 16384 by default); i_req.ready is low
// meanwhile. The accept table and all scan state clear at once.
// An eight-deep result queue decouples the sides: requests keep flowing while
// results wait, and after the clearing pass i_req.ready drops only when the
// queue cannot take the worst case of two results for each request in flight.
module table_dfa_tokenizer #(
    parameter int NUM_STATES = tdt_pkg::NUM_STATES_DEF,
    parameter int MAX_LEXEME = tdt_pkg::MAX_LEXEME_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tdt_req_if.sink                     i_req,
    tdt_res_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [tdt_pkg::STATE_W-1:0] i_cfg_wdata
);

    localparam int ROWS     = (NUM_STATES < tdt_pkg::STATE_SPACE) ?
                              NUM_STATES : tdt_pkg::STATE_SPACE;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TR_DEPTH = ROWS * (2 ** tdt_pkg::CHAR_W);
    localparam int TR_AW    = ROW_W + tdt_pkg::CHAR_W;
    localparam int LEN_W    = $clog2(MAX_LEXEME + 1);
    localparam int FIFO_AW  = $clog2(tdt_pkg::RES_FIFO_DEPTH);
    localparam int CNT_W    = FIFO_AW + 1;
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LEXEME);
    localparam logic [CNT_W-1:0] CNT_ROOM  =
        CNT_W'(tdt_pkg::RES_FIFO_DEPTH - 2 * tdt_pkg::RES_MAX_PER_ITEM);
    localparam logic [TR_AW-1:0] CLR_LAST  = TR_AW'(TR_DEPTH - 1);

    function automatic logic state_ok(input logic [tdt_pkg::STATE_W-1:0] st);
        return 32'(st) < ROWS;
    endfunction

    // Memories
    tdt_pkg::t_trans                r_tr_mem [TR_DEPTH];
    logic [tdt_pkg::TOKEN_W-1:0]    r_acc_mem [ROWS];
    logic [ROWS-1:0]                r_acc_vld;

    // Clearing pass
    logic                           r_clr_busy;
    logic [TR_AW-1:0]               r_clr_addr;

    // Scan state
    logic [tdt_pkg::STATE_W-1:0]    r_start;
    logic [tdt_pkg::STATE_W-1:0]    r_cur;
    logic [tdt_pkg::STATE_W-1:0]    n_cur;
    logic [LEN_W-1:0]               r_len;
    logic [LEN_W-1:0]               n_len;
    logic                           r_skip;
    logic                           n_skip;

    // Resolve stage
    logic                           r_b_vld;
    logic                           r_b_end;
    logic [tdt_pkg::CHAR_W-1:0]     r_b_ch;
    logic                           r_b_cur_ok;
    logic                           r_b_st_ok;
    logic                           r_b_acc;
    logic [tdt_pkg::TOKEN_W-1:0]    r_acc_kind;
    tdt_pkg::t_trans                r_td;
    tdt_pkg::t_trans                r_sd;

    // Result queue
    tdt_pkg::t_result               r_fifo [tdt_pkg::RES_FIFO_DEPTH];
    logic [FIFO_AW-1:0]             r_wr;
    logic [FIFO_AW-1:0]             r_rd;
    logic [CNT_W-1:0]               r_cnt;

    logic                           w_in_acc;
    logic                           w_pop;
    logic                           w_tr_we;
    logic [TR_AW-1:0]               w_tr_waddr;
    tdt_pkg::t_trans                w_tr_wdata;
    logic [TR_AW-1:0]               w_rd_cur;
    logic [TR_AW-1:0]               w_rd_start;
    logic                           w_acc_we;
    logic [ROW_W-1:0]               w_cur_idx;
    logic                           w_blank;
    logic                           w_td_hit;
    logic                           w_sd_hit;
    logic [LEN_W-1:0]               w_len_inc;
    logic [LEN_W-1:0]               w_len_first;
    logic [1:0]                     w_push_n;
    tdt_pkg::t_result               w_res0;
    tdt_pkg::t_result               w_res1;
    tdt_pkg::t_result               w_res_tok;
    tdt_pkg::t_result               w_res_inv;
    tdt_pkg::t_result               w_res_end;
    tdt_pkg::t_result               w_head;

    // Handshakes
    assign i_req.ready = !r_clr_busy && (r_cnt <= CNT_ROOM);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_pop       = o_res.valid && o_res.ready;

    // Clear the transition memory after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + TR_AW'(1);
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Transition memory write: clearing pass or table write
    always_comb begin
        w_tr_we    = r_clr_busy ||
                     (w_in_acc && i_req.req_type == tdt_pkg::REQ_WR_TRANS &&
                      state_ok(i_req.from_state) && state_ok(i_req.to_state));
        w_tr_waddr = r_clr_busy ? r_clr_addr : {ROW_W'(i_req.from_state), i_req.char_code};
        w_tr_wdata = '0;
        if (!r_clr_busy && i_req.entry_valid) begin
            w_tr_wdata.valid      = 1'b1;
            w_tr_wdata.next_state = i_req.to_state;
        end
    end

    // Look up from the state the previous beat leaves behind
    assign w_cur_idx  = ROW_W'(n_cur);
    assign w_rd_cur   = {w_cur_idx, i_req.char_code};
    assign w_rd_start = {ROW_W'(r_start), i_req.char_code};

    always_ff @(posedge i_clk) begin
        if (w_tr_we) begin
            r_tr_mem[w_tr_waddr] <= w_tr_wdata;
        end
        if (w_in_acc) begin
            r_td <= r_tr_mem[w_rd_cur];
            r_sd <= r_tr_mem[w_rd_start];
        end
    end

    // Accept table: token codes in memory, valid bits in flops
    assign w_acc_we = w_in_acc && i_req.req_type == tdt_pkg::REQ_WR_ACCEPT &&
                      state_ok(i_req.from_state) &&
                      (32'(i_req.token_kind_in) < tdt_pkg::NUM_TOKEN_KINDS);

    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[ROW_W'(i_req.from_state)] <= i_req.token_kind_in;
        end
        if (w_in_acc) begin
            r_acc_kind <= r_acc_mem[w_cur_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (w_acc_we) begin
            r_acc_vld[ROW_W'(i_req.from_state)] <= i_req.entry_valid;
        end
    end

    // Register the lookup side for the resolve stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= w_in_acc && (i_req.req_type == tdt_pkg::REQ_CHAR ||
                                    i_req.req_type == tdt_pkg::REQ_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_b_end    <= (i_req.req_type == tdt_pkg::REQ_END);
            r_b_ch     <= i_req.char_code;
            r_b_cur_ok <= state_ok(n_cur);
            r_b_st_ok  <= state_ok(r_start);
            r_b_acc    <= state_ok(n_cur) && (n_cur != r_start) && r_acc_vld[w_cur_idx];
        end
    end

    // Resolve: advance the scan and build results
    assign w_blank     = (r_b_ch == tdt_pkg::CH_SPACE) || (r_b_ch == tdt_pkg::CH_NEWLINE);
    assign w_td_hit    = r_b_cur_ok && r_td.valid;
    assign w_sd_hit    = r_b_st_ok && r_sd.valid;
    assign w_len_inc   = (r_len < LEN_MAX) ? r_len + LEN_W'(1) : r_len;
    assign w_len_first = w_blank ? '0 : LEN_W'(1);

    always_comb begin
        w_res_tok = '{kind: tdt_pkg::RES_TOKEN, token_kind: r_acc_kind,
                      lexeme_length: tdt_pkg::LENGTH_W'(r_len), last: 1'b1};
        w_res_inv = '{kind: tdt_pkg::RES_INVALID, token_kind: '0,
                      lexeme_length: tdt_pkg::LENGTH_W'(r_len), last: 1'b1};
        w_res_end = '{kind: tdt_pkg::RES_END, token_kind: '0,
                      lexeme_length: '0, last: 1'b1};
    end

    always_comb begin
        n_cur    = r_cur;
        n_len    = r_len;
        n_skip   = r_skip;
        w_push_n = 2'd0;
        w_res0   = w_res_end;
        w_res1   = w_res_end;
        if (r_b_vld) begin
            if (r_b_end) begin
                // flush what is pending, then close the stream
                n_cur  = r_start;
                n_len  = '0;
                n_skip = 1'b0;
                if (r_skip || r_len != '0) begin
                    w_push_n    = 2'd2;
                    w_res0      = (!r_skip && r_b_acc) ? w_res_tok : w_res_inv;
                    w_res0.last = 1'b0;
                end else begin
                    w_push_n = 2'd1;
                end
            end else begin
                priority if (r_skip) begin
                    // drop characters until one leaves the start state
                    if (w_sd_hit) begin
                        w_push_n = 2'd1;
                        w_res0   = w_res_inv;
                        n_cur    = r_sd.next_state;
                        n_len    = w_len_first;
                        n_skip   = 1'b0;
                    end else begin
                        n_len = w_len_inc;
                    end
                end else if (w_td_hit) begin
                    n_cur = r_td.next_state;
                    n_len = w_blank ? r_len : w_len_inc;
                end else begin
                    // token ends here: emit it or the invalid run, then rescan this character; with no start edge, skip
                    if (r_b_acc) begin
                        w_push_n = 2'd1;
                        w_res0   = w_res_tok;
                    end else if (w_sd_hit) begin
                        w_push_n = 2'd1;
                        w_res0   = w_res_inv;
                    end
                    if (w_sd_hit) begin
                        n_cur  = r_sd.next_state;
                        n_len  = w_len_first;
                        n_skip = 1'b0;
                    end else begin
                        if (r_b_acc) begin
                            n_cur = r_start;
                            n_len = LEN_W'(1);
                        end else begin
                            n_len = w_len_inc;
                        end
                        n_skip = 1'b1;
                    end
                end
            end
        end
    end

    // Scan state and start register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_cur   <= '0;
            r_len   <= '0;
            r_skip  <= 1'b0;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_wdata;
            r_cur   <= i_cfg_wdata;
            r_len   <= '0;
            r_skip  <= 1'b0;
        end else begin
            r_cur  <= n_cur;
            r_len  <= n_len;
            r_skip <= n_skip;
        end
    end

    // Result queue: push up to two beats, pop one
    always_ff @(posedge i_clk) begin
        if (w_push_n != 2'd0) begin
            r_fifo[r_wr] <= w_res0;
        end
        if (w_push_n == 2'd2) begin
            r_fifo[r_wr + FIFO_AW'(1)] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(w_push_n);
            r_rd  <= r_rd + FIFO_AW'(w_pop);
            r_cnt <= r_cnt + CNT_W'(w_push_n) - CNT_W'(w_pop);
        end
    end

    // Present the head beat
    assign w_head              = r_fifo[r_rd];
    assign o_res.valid         = (r_cnt != '0);
    assign o_res.result_kind   = w_head.kind;
    assign o_res.token_kind    = w_head.token_kind;
    assign o_res.lexeme_length = w_head.lexeme_length;
    assign o_res.last          = w_head.last;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int ST_W = tdt_pkg::STATE_W;
    localparam int CH_W = tdt_pkg::CHAR_W;
    localparam int TK_W = tdt_pkg::TOKEN_W;
    localparam int LN_W = tdt_pkg::LENGTH_W;

    // One request beat as the driver builds it
    typedef struct {
        tdt_pkg::t_req_type  req_type;
        logic [CH_W-1:0]     char_code;
        logic [ST_W-1:0]     from_state;
        logic [ST_W-1:0]     to_state;
        logic                entry_valid;
        logic [TK_W-1:0]     token_kind_in;
    } t_req_beat;

    // Lexer mirror: own copy of both tables and the scan state, plus the queue
    // of result beats still owed by the block
    class t_token_scoreboard;
        tdt_pkg::t_trans     trans_mem [tdt_pkg::STATE_SPACE * 256];
        logic                acc_valid [tdt_pkg::STATE_SPACE];
        logic [TK_W-1:0]     acc_kind [tdt_pkg::STATE_SPACE];
        logic [ST_W-1:0]     start_st;
        logic [ST_W-1:0]     cur_st;
        int                  run_len;
        bit                  skipping;
        tdt_pkg::t_result    staged[$];
        tdt_pkg::t_result    want_results[$];
        int                  errors;

        function new();
            foreach (trans_mem[i]) trans_mem[i] = '0;
            foreach (acc_valid[i]) begin
                acc_valid[i] = 1'b0;
                acc_kind[i]  = '0;
            end
            start_st = '0;
            errors   = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            cur_st   = start_st;
            run_len  = 0;
            skipping = 1'b0;
        endfunction

        function void set_start(logic [ST_W-1:0] v);
            start_st = v;
            restart_scan();
        endfunction

        // Saturate the running length
        function void bump_len();
            if (run_len < tdt_pkg::MAX_LEXEME_DEF) run_len++;
        endfunction

        // Follow a valid edge; blanks walk but do not count
        function void take_edge(tdt_pkg::t_trans t, logic [CH_W-1:0] ch);
            cur_st = t.next_state;
            if (ch != tdt_pkg::CH_SPACE && ch != tdt_pkg::CH_NEWLINE) bump_len();
        endfunction

        // The start state never accepts
        function bit accepting(logic [ST_W-1:0] st);
            return (st != start_st) && acc_valid[st];
        endfunction

        function void stage(tdt_pkg::t_res_kind kind, logic [TK_W-1:0] tok, int len);
            tdt_pkg::t_result r;
            r.kind          = kind;
            r.token_kind    = tok;
            r.lexeme_length = len[LN_W-1:0];
            r.last          = 1'b0;
            staged = {staged, r};
        endfunction

        function void scan_char(logic [CH_W-1:0] ch);
            tdt_pkg::t_trans from_start;
            tdt_pkg::t_trans from_cur;
            from_start = trans_mem[{start_st, ch}];
            // While skipping, count everything until the start state can move
            if (skipping) begin
                if (from_start.valid) begin
                    stage(tdt_pkg::RES_INVALID, '0, run_len);
                    restart_scan();
                    take_edge(from_start, ch);
                end else begin
                    bump_len();
                end
                return;
            end
            from_cur = trans_mem[{cur_st, ch}];
            if (from_cur.valid) begin
                take_edge(from_cur, ch);
                return;
            end
            // No edge: close the token if the state accepts, else report junk
            if (accepting(cur_st)) begin
                stage(tdt_pkg::RES_TOKEN, acc_kind[cur_st], run_len);
            end else if (from_start.valid) begin
                stage(tdt_pkg::RES_INVALID, '0, run_len);
            end
            if (accepting(cur_st) || from_start.valid) begin
                restart_scan();
            end
            if (from_start.valid) begin
                take_edge(from_start, ch);
            end else begin
                skipping = 1'b1;
                bump_len();
            end
        endfunction

        function void flush_input();
            if (skipping) begin
                stage(tdt_pkg::RES_INVALID, '0, run_len);
            end else if (run_len != 0) begin
                if (accepting(cur_st)) stage(tdt_pkg::RES_TOKEN, acc_kind[cur_st], run_len);
                else stage(tdt_pkg::RES_INVALID, '0, run_len);
            end
            stage(tdt_pkg::RES_END, '0, 0);
            restart_scan();
        endfunction

        function void take_request(t_req_beat b);
            tdt_pkg::t_trans entry;
            staged.delete();
            case (b.req_type)
                tdt_pkg::REQ_CHAR: begin
                    scan_char(b.char_code);
                end
                tdt_pkg::REQ_END: begin
                    flush_input();
                end
                tdt_pkg::REQ_WR_TRANS: begin
                    entry.valid      = b.entry_valid;
                    entry.next_state = b.entry_valid ? b.to_state : '0;
                    trans_mem[{b.from_state, b.char_code}] = entry;
                end
                default: begin
                    // Out-of-range token codes leave the entry alone
                    if (b.token_kind_in < tdt_pkg::NUM_TOKEN_KINDS) begin
                        acc_valid[b.from_state] = b.entry_valid;
                        acc_kind[b.from_state]  = b.entry_valid ? b.token_kind_in : '0;
                    end
                end
            endcase
            if (staged.size() != 0) begin
                staged[staged.size() - 1].last = 1'b1;
            end
            want_results = {want_results, staged};
        endfunction

        function void check_result(tdt_pkg::t_result got);
            tdt_pkg::t_result want;
            if (want_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat kind %0d token %0d length %0d last %0d",
                         $time, got.kind, got.token_kind, got.lexeme_length, got.last);
                return;
            end
            want = want_results.pop_front();
            if (got.kind !== want.kind) begin
                errors++;
                $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
            end
            if (got.token_kind !== want.token_kind) begin
                errors++;
                $display("%0t: token_kind expected %0d actual %0d",
                         $time, want.token_kind, got.token_kind);
            end
            if (got.lexeme_length !== want.lexeme_length) begin
                errors++;
                $display("%0t: lexeme_length expected %0d actual %0d",
                         $time, want.lexeme_length, got.lexeme_length);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [ST_W-1:0]     i_cfg_wdata;

    tdt_req_if req_ch ();
    tdt_res_if res_ch ();

    t_token_scoreboard sb;
    bit                req_calm;
    bit                res_calm;
    int                sent;

    table_dfa_tokenizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop if the block hangs
    initial begin
        #(64'd10_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // Fill the don't-care fields with random bits
    function automatic t_req_beat noise_beat(tdt_pkg::t_req_type rt);
        t_req_beat b;
        b.req_type      = rt;
        b.char_code     = CH_W'($urandom_range(0, 255));
        b.from_state    = ST_W'($urandom_range(0, tdt_pkg::STATE_SPACE - 1));
        b.to_state      = ST_W'($urandom_range(0, tdt_pkg::STATE_SPACE - 1));
        b.entry_valid   = 1'($urandom_range(0, 1));
        b.token_kind_in = TK_W'($urandom_range(0, 15));
        return b;
    endfunction

    // Present one request beat after a random gap and hold until taken
    task automatic drive_req(t_req_beat b);
        int gap;
        if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
        gap = req_calm ? 0 : int'($urandom_range(0, 18));
        @(negedge i_clk);
        if (gap != 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.req_type      = b.req_type;
        req_ch.char_code     = b.char_code;
        req_ch.from_state    = b.from_state;
        req_ch.to_state      = b.to_state;
        req_ch.entry_valid   = b.entry_valid;
        req_ch.token_kind_in = b.token_kind_in;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.take_request(b);
        sent++;
    endtask

    task automatic send_char(logic [CH_W-1:0] ch);
        t_req_beat b;
        b = noise_beat(tdt_pkg::REQ_CHAR);
        b.char_code = ch;
        drive_req(b);
    endtask

    task automatic send_end();
        drive_req(noise_beat(tdt_pkg::REQ_END));
    endtask

    task automatic send_trans(logic [ST_W-1:0] src, logic [CH_W-1:0] ch,
                              logic [ST_W-1:0] dst, logic v);
        t_req_beat b;
        b = noise_beat(tdt_pkg::REQ_WR_TRANS);
        b.from_state  = src;
        b.char_code   = ch;
        b.to_state    = dst;
        b.entry_valid = v;
        drive_req(b);
    endtask

    task automatic send_accept(logic [ST_W-1:0] st, logic [TK_W-1:0] kind, logic v);
        t_req_beat b;
        b = noise_beat(tdt_pkg::REQ_WR_ACCEPT);
        b.from_state    = st;
        b.token_kind_in = kind;
        b.entry_valid   = v;
        drive_req(b);
    endtask

    // Drop valid, drain all owed results, let the pipe settle, then write
    task automatic write_start(logic [ST_W-1:0] v);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (sb.want_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(posedge i_clk);
        sb.set_start(v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Result side: random back-pressure, check every beat taken
    initial begin : res_side
        tdt_pkg::t_result got;
        int               gap;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) res_calm = !res_calm;
            gap = res_calm ? 0 : int'($urandom_range(0, 18));
            @(negedge i_clk);
            if (gap != 0) begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            got.kind          = res_ch.result_kind;
            got.token_kind    = res_ch.token_kind;
            got.lexeme_length = res_ch.lexeme_length;
            got.last          = res_ch.last;
            sb.check_result(got);
        end
    end

    initial begin : req_side
        logic [CH_W-1:0]  alpha[$];
        logic [ST_W-1:0]  states[$];
        logic [ST_W-1:0]  st;
        logic [ST_W-1:0]  x;
        logic [CH_W-1:0]  c;
        int               phase;
        int               n;
        int               r;

        sb                   = new();
        req_calm             = 1'b0;
        res_calm             = 1'b0;
        sent                 = 0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = tdt_pkg::REQ_CHAR;
        req_ch.char_code     = '0;
        req_ch.from_state    = '0;
        req_ch.to_state      = '0;
        req_ch.entry_valid   = 1'b0;
        req_ch.token_kind_in = '0;

        // Hold reset, then release it on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Small hand-built lexer from start state 0
        send_trans(6'd0, "a", 6'd1, 1'b1);
        send_trans(6'd1, "a", 6'd1, 1'b1);
        send_trans(6'd1, tdt_pkg::CH_SPACE, 6'd1, 1'b1);
        send_trans(6'd0, 8'hFF, 6'd63, 1'b1);
        send_trans(6'd63, 8'h00, 6'd63, 1'b1);
        send_accept(6'd1, 4'd12, 1'b1);
        send_accept(6'd63, 4'd0, 1'b1);
        send_accept(6'd0, 4'd5, 1'b1);       // start state must still not accept
        send_accept(6'd2, 4'd13, 1'b1);      // token code out of range: ignored
        send_char("a");
        send_char(tdt_pkg::CH_SPACE);        // blank inside a token is not counted
        send_char("a");
        send_char(8'hFF);                    // closes token, restarts on same char
        send_char(8'h00);
        send_char("z");                      // token, then no start edge: skip
        send_char(tdt_pkg::CH_NEWLINE);
        send_char("a");                      // start edge ends the skipped text
        send_end();
        send_end();                          // nothing pending: end only
        send_trans(6'd1, "a", 6'd1, 1'b0);   // clear an edge
        send_char("a");
        send_char("a");
        // New start state drops the pending token; start state never accepts
        write_start(6'd63);
        send_char(8'h00);
        send_end();

        // Random lexers, mostly fed from their own alphabet
        phase = 0;
        while (sent < 1320) begin
            r = $urandom_range(0, 3);
            st = (phase == 0) ? 6'd0 : (r == 0) ? 6'd0 : (r == 1) ? 6'd63 :
                 ST_W'($urandom_range(0, tdt_pkg::STATE_SPACE - 1));
            write_start(st);

            states.delete();
            alpha.delete();
            states = {states, st};
            repeat ($urandom_range(1, 5)) begin
                states = {states, ST_W'($urandom_range(0, tdt_pkg::STATE_SPACE - 1))};
            end
            repeat ($urandom_range(3, 8)) alpha = {alpha, CH_W'($urandom_range(0, 255))};
            if ($urandom_range(0, 1) == 1) begin
                alpha = {alpha, tdt_pkg::CH_SPACE, tdt_pkg::CH_NEWLINE};
            end

            // Load edges: mostly set, some cleared
            foreach (states[i]) begin
                foreach (alpha[j]) begin
                    r = $urandom_range(0, 9);
                    if (r < 6) begin
                        send_trans(states[i], alpha[j],
                                   states[$urandom_range(0, states.size() - 1)], 1'b1);
                    end else if (r < 8) begin
                        send_trans(states[i], alpha[j], ST_W'($urandom_range(0, 63)), 1'b0);
                    end
                end
                r = $urandom_range(0, 9);
                if (r < 7) send_accept(states[i], TK_W'($urandom_range(0, 12)), 1'b1);
                else if (r < 9) send_accept(states[i], TK_W'($urandom_range(0, 12)), 1'b0);
                else send_accept(states[i], TK_W'($urandom_range(13, 15)),
                                 1'($urandom_range(0, 1)));
            end

            // Once, drive a token and a skipped run past saturation
            if (phase == 2) begin
                c = CH_W'($urandom_range(8'h21, 8'h7E));
                x = ST_W'($urandom_range(0, tdt_pkg::STATE_SPACE - 1));
                if (x == st) x = x ^ 6'd1;
                send_trans(st, c, x, 1'b1);
                send_trans(x, c, x, 1'b1);
                send_accept(x, TK_W'($urandom_range(0, 12)), 1'b1);
                repeat (300) send_char(c);
                send_end();
                c = c ^ 8'h80;
                send_trans(st, c, x, 1'b0);
                repeat (280) send_char(c);
                send_end();
            end

            // Character stream with stray bytes and early ends
            n = $urandom_range(30, 90);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 4) send_end();
                else if (r < 82) send_char(alpha[$urandom_range(0, alpha.size() - 1)]);
                else send_char(CH_W'($urandom_range(0, 255)));
            end
            send_end();
            phase++;
        end

        // Drain and settle
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (sb.want_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.want_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tdt_pkg.sv
src/tdt_req_if.sv
src/tdt_res_if.sv
src/table_dfa_tokenizer.sv
verif/tb.sv
